// ===== design/tkss_pkg.sv =====
// Shared types and constants for the top-K score selector.
// Used by every module of the block; no dependencies of its own.
package tkss_pkg;

    localparam int TOP_COUNT   = 5;
    localparam int MAX_CLASSES = 1024;
    localparam int SCORE_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_CLASSES);
    localparam int RANK_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SCORE_BITS-1:0] THRESH_RESET  = SCORE_BITS'(19661);
    localparam logic [IDX_W-1:0]      LAST_POSITION = IDX_W'(MAX_CLASSES - 1);
    localparam logic [RANK_W-1:0]     LAST_RANK     = RANK_W'(TOP_COUNT - 1);

    // Sorted top list, slot 0 highest; valid is always a run of low bits
    typedef struct packed {
        logic [TOP_COUNT-1:0]                 valid;
        logic [TOP_COUNT-1:0][IDX_W-1:0]      index;
        logic [TOP_COUNT-1:0][SCORE_BITS-1:0] score;
    } topk_list_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

endpackage

// ===== design/tkss_front.sv =====
// Front end of the top-K selector: accepts scores and inserts each into the sorted list.
// On a last item pushes the finished list to the snapshot queue. Depends on tkss_pkg.
module tkss_front import tkss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SCORE_BITS-1:0] s_score,
    input  logic                  s_last,
    input  queue_status_t         q_status,
    output logic                  push,
    output topk_list_t            push_list
);

    topk_list_t           list_reg, list_next, list_ins;
    logic [IDX_W-1:0]     position_reg, position_next;
    logic [TOP_COUNT-1:0] gt;
    logic [TOP_COUNT-1:0] first;
    logic                 accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && s_last;

    // gt is a thermometer: once the new score beats a slot it beats all below
    always_comb begin
        for (int k = 0; k < TOP_COUNT; k++) begin
            gt[k] = !list_reg.valid[k] || (s_score > list_reg.score[k]);
        end
        first = gt & ~(gt << 1);

        list_ins = list_reg;
        if (gt[0]) begin
            list_ins.score[0] = s_score;
            list_ins.index[0] = position_reg;
            list_ins.valid[0] = 1'b1;
        end
        for (int k = 1; k < TOP_COUNT; k++) begin
            if (first[k]) begin
                list_ins.score[k] = s_score;
                list_ins.index[k] = position_reg;
                list_ins.valid[k] = 1'b1;
            end else if (gt[k]) begin
                list_ins.score[k] = list_reg.score[k-1];
                list_ins.index[k] = list_reg.index[k-1];
                list_ins.valid[k] = list_reg.valid[k-1];
            end
        end
    end

    assign push_list = list_ins;

    always_comb begin
        list_next     = list_reg;
        position_next = position_reg;
        if (accept) begin
            list_next = list_ins;
            if (position_reg != LAST_POSITION) begin
                position_next = position_reg + IDX_W'(1);
            end
            if (s_last) begin
                list_next.valid = '0;
                position_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        list_reg.score <= list_next.score;
        list_reg.index <= list_next.index;
        if (!aresetn) begin
            list_reg.valid <= '0;
            position_reg   <= '0;
        end else begin
            list_reg.valid <= list_next.valid;
            position_reg   <= position_next;
        end
    end

`ifndef SYNTHESIS
    // Filled slots always form a prefix of the list
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((list_reg.valid & (list_reg.valid + TOP_COUNT'(1))) == '0))
        else $error("top list valid bits are not a prefix");
`endif

endmodule

// ===== design/tkss_queue.sv =====
// Snapshot queue between the insertion front end and the result emitter.
// Holds finished top lists in registers. Depends on tkss_pkg.
module tkss_queue import tkss_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  topk_list_t    push_list,
    input  logic          pop,
    output queue_status_t q_status,
    output topk_list_t    head_list
);

    topk_list_t                          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]                   count_reg, count_next;

    assign q_status.full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.head_valid = (count_reg != '0);
    assign head_list           = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_list;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !push)
        else $error("snapshot queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.head_valid)
        else $error("snapshot queue read while empty");
`endif

endmodule

// ===== design/tkss_back.sv =====
// Result emitter of the top-K selector: walks the head snapshot rank by rank into
// a registered output stage and releases the snapshot after the last rank. Depends on tkss_pkg.
module tkss_back import tkss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  queue_status_t         q_status,
    input  topk_list_t            head_list,
    input  logic [SCORE_BITS-1:0] threshold,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RANK_W-1:0]     m_rank,
    output logic [IDX_W-1:0]      m_class_index,
    output logic [SCORE_BITS-1:0] m_top_score,
    output logic                  m_filled,
    output logic                  m_accepted,
    output logic                  m_end_of_run
);

    logic [RANK_W-1:0]     rank_reg, rank_next;
    logic                  m_valid_reg, m_valid_next;
    logic [RANK_W-1:0]     m_rank_reg;
    logic [IDX_W-1:0]      m_index_reg;
    logic [SCORE_BITS-1:0] m_score_reg;
    logic                  m_filled_reg, m_accepted_reg, m_end_reg;
    logic                  load, is_last_rank, slot_filled;

    assign load         = q_status.head_valid && (!m_valid_reg || m_ready);
    assign is_last_rank = (rank_reg == LAST_RANK);
    assign pop          = load && is_last_rank;
    assign slot_filled  = head_list.valid[rank_reg];

    always_comb begin
        rank_next    = rank_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            rank_next    = is_last_rank ? '0 : rank_reg + RANK_W'(1);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_rank_reg     <= rank_reg;
            m_index_reg    <= slot_filled ? head_list.index[rank_reg] : '0;
            m_score_reg    <= slot_filled ? head_list.score[rank_reg] : '0;
            m_filled_reg   <= slot_filled;
            m_accepted_reg <= head_list.valid[0] && (head_list.score[0] >= threshold);
            m_end_reg      <= is_last_rank;
        end
        if (!aresetn) begin
            rank_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rank        = m_rank_reg;
    assign m_class_index = m_index_reg;
    assign m_top_score   = m_score_reg;
    assign m_filled      = m_filled_reg;
    assign m_accepted    = m_accepted_reg;
    assign m_end_of_run  = m_end_reg;

`ifndef SYNTHESIS
    a_end_on_last_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_end_reg == (m_rank_reg == LAST_RANK)))
        else $error("end of run flag does not match the final rank");
    a_empty_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_filled_reg) |-> (m_score_reg == '0 && m_index_reg == '0))
        else $error("unfilled rank carries a nonzero payload");
`endif

endmodule

// ===== design/top_k_score_select.sv =====
// Top level of the streaming top-K score selector with class index.
// Instantiates tkss_front, tkss_queue and tkss_back; depends on tkss_pkg.
//
// Scores arrive one per cycle on the s_ channel; each is inserted into a sorted list of the
// TOP_COUNT best scores in the cycle it is accepted (parallel compares against every slot, ties
// keep the earlier class first), so s_ready stays high at one item per cycle while the queue
// has room. On the item marked last the finished list goes into a two-entry snapshot queue
// and the front end starts the next vector at once. The emitter then delivers TOP_COUNT results,
// one per cycle while m_ready holds, through a registered output stage; the list is registered
// in the queue before rank 0 is presented. s_ready drops only while both snapshot entries wait,
// which happens when vectors shorter than TOP_COUNT items arrive faster than their results
// drain or when m_ready stalls the emitter; it stays low in the cycle that frees an entry and
// rises in the next. The threshold is written on the cfg_ channel, accepted every cycle.
module top_k_score_select import tkss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SCORE_BITS-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SCORE_BITS-1:0] s_score,
    input  logic                  s_last,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RANK_W-1:0]     m_rank,
    output logic [IDX_W-1:0]      m_class_index,
    output logic [SCORE_BITS-1:0] m_top_score,
    output logic                  m_filled,
    output logic                  m_accepted,
    output logic                  m_end_of_run
);

    logic [SCORE_BITS-1:0] threshold_reg;
    queue_status_t         q_status;
    topk_list_t            push_list, head_list;
    logic                  push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESH_RESET;
        end else if (cfg_valid) begin
            threshold_reg <= cfg_data;
        end
    end

    tkss_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_score   (s_score),
        .s_last    (s_last),
        .q_status  (q_status),
        .push      (push),
        .push_list (push_list)
    );

    tkss_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_list (push_list),
        .pop       (pop),
        .q_status  (q_status),
        .head_list (head_list)
    );

    tkss_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .head_list     (head_list),
        .threshold     (threshold_reg),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rank        (m_rank),
        .m_class_index (m_class_index),
        .m_top_score   (m_top_score),
        .m_filled      (m_filled),
        .m_accepted    (m_accepted),
        .m_end_of_run  (m_end_of_run)
    );

endmodule
